@@ src/tdts_pkg.sv @@
`default_nettype none
package tdts_pkg;

  localparam int FRAC_BITS = 8;
  localparam int VAL_W = 16;
  localparam int EXT_W = 22;

  localparam logic signed [VAL_W-1:0] FULL = VAL_W'(100 << FRAC_BITS);
  localparam int Q_W = $clog2(100 << FRAC_BITS);
  localparam logic [Q_W-1:0] FULL_U = Q_W'(100 << FRAC_BITS);

  localparam logic signed [17:0] DEG_P20 = 18'(20 << FRAC_BITS);
  localparam logic signed [17:0] DEG_P30 = 18'(30 << FRAC_BITS);
  localparam logic signed [17:0] DEG_N20 = -18'(20 << FRAC_BITS);
  localparam logic signed [17:0] DEG_N30 = -18'(30 << FRAC_BITS);

  localparam int TENS_W = 24;
  localparam int RAW_W = 23;
  localparam int REM_W = Q_W + TENS_W;
  localparam int CNT_W = $clog2(Q_W);

  localparam logic [14:0] SLEW_RST = 15'd51;
  localparam logic [15:0] TIMEOUT_RST = 16'd2000;
  localparam logic [RAW_W-1:0] TFULL_RST = RAW_W'(750000);
  localparam logic [RAW_W-1:0] TZERO_RST = RAW_W'(2250000);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 23;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TFULL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TZERO = 2'd3;

  localparam int IN_DATA_W = 128;
  localparam int OUT_DATA_W = 56;

  typedef struct packed {
    logic load;
    logic do_set;
    logic do_time;
    logic do_slew;
    logic do_tilt;
    logic do_tens;
    logic do_mul;
    logic div_step;
    logic do_fwd;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_sts_t;

  function automatic logic signed [VAL_W-1:0] sat_full(input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] hi;
    logic signed [VAL_W-1:0] res;
    hi = EXT_W'(FULL);
    if (v > hi) res = FULL;
    else if (v < -hi) res = -FULL;
    else res = v[VAL_W-1:0];
    return res;
  endfunction

endpackage
`default_nettype wire

@@ src/tdts_ctrl.sv @@
`default_nettype none
module tdts_ctrl
  import tdts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  input  wire logic in_tuser,
  output logic      in_tready,
  output logic      out_tvalid,
  input  wire logic out_tready,
  input  dp_sts_t   sts,
  output dp_cmd_t   cmd
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_SET  = 10'b0000000010,
    ST_TIME = 10'b0000000100,
    ST_SLEW = 10'b0000001000,
    ST_TILT = 10'b0000010000,
    ST_TENS = 10'b0000100000,
    ST_MUL  = 10'b0001000000,
    ST_DIV  = 10'b0010000000,
    ST_FWD  = 10'b0100000000,
    ST_RES  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic in_acc, slot_free;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.load = in_acc;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = in_tuser ? ST_TIME : ST_SET;
      end
      ST_SET: begin
        cmd.do_set = 1'b1;
        state_nxt = ST_RES;
      end
      ST_TIME: begin
        cmd.do_time = 1'b1;
        state_nxt = ST_SLEW;
      end
      ST_SLEW: begin
        cmd.do_slew = 1'b1;
        state_nxt = ST_TILT;
      end
      ST_TILT: begin
        cmd.do_tilt = 1'b1;
        state_nxt = ST_TENS;
      end
      ST_TENS: begin
        cmd.do_tens = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.do_mul = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_FWD;
      end
      ST_FWD: begin
        cmd.do_fwd = 1'b1;
        state_nxt = ST_RES;
      end
      ST_RES: begin
        // wait for the output register to free up
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/tdts_dp.sv @@
`default_nettype none
module tdts_dp
  import tdts_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic      [OUT_DATA_W-1:0] out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  dp_cmd_t                    cmd,
  output dp_sts_t                    sts
);

  // configuration
  logic [14:0] slew_r;
  logic [15:0] timeout_r;
  logic [RAW_W-1:0] tfull_r, tzero_r;

  // captured item
  logic [31:0] now_r;
  logic signed [VAL_W-1:0] thr_cmd_r, yaw_cmd_r, corr_r;
  logic signed [16:0] pitch_r;
  logic signed [TENS_W-1:0] tens_r;
  logic batt_r;

  // block state
  logic signed [VAL_W-1:0] thr_tgt_r, yaw_tgt_r, thr_now_r, yaw_now_r;
  logic [31:0] last_ms_r;
  logic fired_r;

  // working values
  logic signed [VAL_W-1:0] t_r;
  logic le_full_r, ge_zero_r;
  logic [TENS_W-1:0] diff_r;
  logic [RAW_W-1:0] den_r;
  logic [REM_W-1:0] rem_r, dd_r;
  logic [Q_W-1:0] q_r;
  logic [CNT_W-1:0] cnt_r;

  logic [OUT_DATA_W-1:0] out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slew_r <= SLEW_RST;
      timeout_r <= TIMEOUT_RST;
      tfull_r <= TFULL_RST;
      tzero_r <= TZERO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLEW:    slew_r <= cfg_wdata[14:0];
        CFG_TIMEOUT: timeout_r <= cfg_wdata[15:0];
        CFG_TFULL:   tfull_r <= cfg_wdata[RAW_W-1:0];
        CFG_TZERO:   tzero_r <= cfg_wdata[RAW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r <= in_tdata[31:0];
      thr_cmd_r <= in_tdata[47:32];
      yaw_cmd_r <= in_tdata[63:48];
      pitch_r <= in_tdata[80:64];
      tens_r <= in_tdata[104:81];
      corr_r <= in_tdata[120:105];
      batt_r <= in_tdata[121];
    end
  end

  // timeout
  logic [31:0] deadline;
  logic fire;
  assign deadline = last_ms_r + {16'b0, timeout_r};
  assign fire = (last_ms_r != 32'd0) && (now_r >= deadline);

  // slew with fast stop
  logic signed [16:0] diff17, adiff17;
  logic [VAL_W-1:0] atgt, anow;
  logic opp;
  logic signed [EXT_W-1:0] stepped;
  logic signed [VAL_W-1:0] slew_res;

  always_comb begin
    diff17 = 17'(thr_tgt_r) - 17'(thr_now_r);
    adiff17 = diff17[16] ? -diff17 : diff17;
    atgt = thr_tgt_r[VAL_W-1] ? VAL_W'(-thr_tgt_r) : VAL_W'(thr_tgt_r);
    anow = thr_now_r[VAL_W-1] ? VAL_W'(-thr_now_r) : VAL_W'(thr_now_r);
    opp = (thr_now_r > 0 && thr_tgt_r < 0) || (thr_now_r < 0 && thr_tgt_r > 0);
    if (thr_tgt_r > thr_now_r) stepped = EXT_W'(thr_now_r) + EXT_W'(slew_r);
    else stepped = EXT_W'(thr_now_r) - EXT_W'(slew_r);
    if (17'(adiff17) <= {2'b0, slew_r}) slew_res = thr_tgt_r;
    else if (opp) slew_res = '0;
    else if (atgt <= anow) slew_res = thr_tgt_r;
    else slew_res = sat_full(stepped);
  end

  // tilt limits, slope of ten between the two points
  logic signed [EXT_W-1:0] p22, pd_lo, pd_hi, tmin, tmax, t22;
  logic signed [VAL_W-1:0] tilt_res;

  always_comb begin
    p22 = EXT_W'(pitch_r);
    pd_lo = p22 - EXT_W'(DEG_P20);
    pd_hi = p22 - EXT_W'(DEG_N30);
    if (pitch_r <= DEG_P20) tmin = -EXT_W'(FULL);
    else if (pitch_r >= DEG_P30) tmin = '0;
    else tmin = -EXT_W'(FULL) + (pd_lo <<< 3) + (pd_lo <<< 1);
    if (pitch_r <= DEG_N30) tmax = '0;
    else if (pitch_r >= DEG_N20) tmax = EXT_W'(FULL);
    else tmax = (pd_hi <<< 3) + (pd_hi <<< 1);
    t22 = EXT_W'(t_r);
    if (t22 < tmin) tilt_res = tmin[VAL_W-1:0];
    else if (t22 > tmax) tilt_res = tmax[VAL_W-1:0];
    else tilt_res = t_r;
  end

  // tension compare
  logic signed [TENS_W:0] t25, full25, zero25, zdiff25;
  assign t25 = (TENS_W+1)'(tens_r);
  assign full25 = {2'b0, tfull_r};
  assign zero25 = {2'b0, tzero_r};
  assign zdiff25 = zero25 - t25;

  // forward limit and mixer
  logic signed [VAL_W-1:0] fmax, fwd_res;
  logic signed [VAL_W-1:0] left_v, right_v;

  always_comb begin
    if (le_full_r) fmax = FULL;
    else if (ge_zero_r) fmax = '0;
    else fmax = VAL_W'(q_r);
    fwd_res = (t_r > fmax) ? fmax : t_r;
    if (batt_r) begin
      left_v = '0;
      right_v = '0;
    end else begin
      left_v = sat_full(EXT_W'(thr_now_r) - EXT_W'(yaw_now_r));
      right_v = sat_full(EXT_W'(thr_now_r) + EXT_W'(yaw_now_r));
    end
  end

  assign sts.div_last = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_tgt_r <= '0;
      yaw_tgt_r <= '0;
      thr_now_r <= '0;
      yaw_now_r <= '0;
      last_ms_r <= '0;
      fired_r <= 1'b0;
    end else begin
      if (cmd.do_set) begin
        thr_tgt_r <= sat_full(EXT_W'(thr_cmd_r));
        yaw_tgt_r <= sat_full(EXT_W'(yaw_cmd_r));
        last_ms_r <= now_r;
        fired_r <= 1'b0;
      end
      if (cmd.do_time) begin
        fired_r <= fire;
        if (fire) begin
          thr_tgt_r <= '0;
          yaw_tgt_r <= '0;
          last_ms_r <= '0;
        end
      end
      if (cmd.do_slew) yaw_now_r <= sat_full(EXT_W'(yaw_tgt_r) + EXT_W'(corr_r));
      if (cmd.do_fwd) thr_now_r <= fwd_res;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_slew) t_r <= slew_res;
    if (cmd.do_tilt) t_r <= tilt_res;
    if (cmd.do_tens) begin
      le_full_r <= (t25 <= full25);
      ge_zero_r <= (t25 >= zero25);
      diff_r <= zdiff25[TENS_W-1:0];
      den_r <= tzero_r - tfull_r;
    end
    // restoring divide, one quotient bit per step
    if (cmd.do_mul) begin
      rem_r <= REM_W'(FULL_U) * REM_W'(diff_r);
      dd_r <= REM_W'(den_r) << (Q_W - 1);
      q_r <= '0;
      cnt_r <= CNT_W'(Q_W - 1);
    end
    if (cmd.div_step) begin
      if (rem_r >= dd_r) begin
        rem_r <= rem_r - dd_r;
        q_r <= {q_r[Q_W-2:0], 1'b1};
      end else begin
        q_r <= {q_r[Q_W-2:0], 1'b0};
      end
      dd_r <= dd_r >> 1;
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (cmd.load_out) begin
      out_r <= {7'b0, fired_r, thr_now_r, right_v, left_v};
    end
  end

  assign out_tdata = out_r;

endmodule
`default_nettype wire

@@ src/tracked_drive_throttle_shaper_unit.sv @@
`default_nettype none
// a set item passes the SET state, a tick item TIME, SLEW, TILT, TENS, MUL, DIV and FWD;
// both end in RES, which loads the output register; one item is processed at a time
// a tick item runs the 15-step restoring divider of the leash tension curve
// a result waiting in the output register does not block acceptance of the next item
// reset: synchronous active-low rst_n clears targets, throttle, yaw and the command stamp
// and loads the configuration registers with their default values
module tracked_drive_throttle_shaper_unit
  import tdts_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // now_ms, throttle_cmd, yaw_cmd, pitch_angle, tension_raw, yaw_correction,
  // battery_very_low, zero fill
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // command
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // left_drive, right_drive, throttle_level, timed_out, zero fill
  output logic      [OUT_DATA_W-1:0] out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tdts_ctrl u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tuser(in_tuser),
    .in_tready(in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts(sts),
    .cmd(cmd)
  );

  tdts_dp u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .in_tdata(in_tdata),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cmd(cmd),
    .sts(sts)
  );

endmodule
`default_nettype wire

@@ src/tdts_checker.sv @@
`default_nettype none
module tdts_sva
  import tdts_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // one item at a time: busy after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after an accepted item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // throttle level and left drive stay within full scale
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[47:32]) <= FULL) && ($signed(out_tdata[47:32]) >= -FULL)
      && ($signed(out_tdata[15:0]) <= FULL) && ($signed(out_tdata[15:0]) >= -FULL))
    else $error("drive value beyond full scale");

endmodule

bind tracked_drive_throttle_shaper_unit tdts_sva u_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_tvalid(in_tvalid),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata)
);
`default_nettype wire

@@ verif/tdts_checker.sv @@
`timescale 1ns / 100ps
module tdts_checker
  import tdts_pkg::*;
#(
  parameter logic TICK_CODE = 1'b1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  in_tuser,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         pending
);

  // fields from the highest bit down, matching the packed result
  typedef struct packed {
    logic                    timed_out;
    logic signed [VAL_W-1:0] level;
    logic signed [VAL_W-1:0] right;
    logic signed [VAL_W-1:0] left;
  } drive_t;

  // shadow configuration
  logic [14:0]      slew_reg;
  logic [15:0]      timeout_reg;
  logic [RAW_W-1:0] tfull_reg;
  logic [RAW_W-1:0] tzero_reg;

  // shadow state
  int          throttle_tgt;
  int          yaw_tgt;
  int          throttle_cur;
  int          yaw_cur;
  logic [31:0] cmd_stamp;

  drive_t drive_q[$];
  int     n_fail = 0;
  int     n_pending = 0;

  assign fail_count = n_fail;
  assign pending = n_pending;

  function automatic int clip(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // advances the shadow state by one item and returns the drives it should produce
  function automatic drive_t shape_item(input logic is_tick, input logic [IN_DATA_W-1:0] d);
    logic [31:0] now;
    logic [31:0] due;
    int          full;
    int          pitch;
    int          corr;
    int          step;
    int          t;
    int          tmin;
    int          tmax;
    int          fmax;
    longint      tens;
    longint      num;
    longint      den;
    drive_t      r;
    full = int'(FULL);
    now = d[31:0];
    r.timed_out = 1'b0;
    if (!is_tick) begin
      throttle_tgt = clip(int'($signed(d[47:32])), -full, full);
      yaw_tgt = clip(int'($signed(d[63:48])), -full, full);
      cmd_stamp = now;
    end else begin
      pitch = int'($signed(d[80:64]));
      tens = longint'($signed(d[104:81]));
      corr = int'($signed(d[120:105]));
      step = int'(slew_reg);
      due = cmd_stamp + {16'd0, timeout_reg};
      if (cmd_stamp != 32'd0 && now >= due) begin
        throttle_tgt = 0;
        yaw_tgt = 0;
        cmd_stamp = 32'd0;
        r.timed_out = 1'b1;
      end
      yaw_cur = clip(yaw_tgt + corr, -full, full);

      // slew with fast stop
      t = throttle_cur;
      if (mag(throttle_tgt - t) <= step) begin
        t = throttle_tgt;
      end else if ((t > 0 && throttle_tgt < 0) || (t < 0 && throttle_tgt > 0)) begin
        t = 0;
      end else if (mag(throttle_tgt) <= mag(t)) begin
        t = throttle_tgt;
      end else begin
        t += (throttle_tgt > t) ? step : -step;
      end
      t = clip(t, -full, full);

      // tilt curves, slope 10 between the break points
      if (pitch <= (20 << FRAC_BITS)) tmin = -full;
      else if (pitch >= (30 << FRAC_BITS)) tmin = 0;
      else tmin = -full + (pitch - (20 << FRAC_BITS)) * 10;
      if (pitch <= -(30 << FRAC_BITS)) tmax = 0;
      else if (pitch >= -(20 << FRAC_BITS)) tmax = full;
      else tmax = (pitch + (30 << FRAC_BITS)) * 10;
      t = clip(t, tmin, tmax);

      // leash tension limits forward only
      if (tens <= longint'(tfull_reg)) begin
        fmax = full;
      end else if (tens >= longint'(tzero_reg)) begin
        fmax = 0;
      end else begin
        num = longint'(full) * (longint'(tzero_reg) - tens);
        den = longint'(tzero_reg) - longint'(tfull_reg);
        fmax = int'(num / den);
      end
      throttle_cur = clip(t, -full, fmax);
    end

    if (d[121]) begin
      r.left = '0;
      r.right = '0;
    end else begin
      r.left = VAL_W'(clip(throttle_cur - yaw_cur, -full, full));
      r.right = VAL_W'(clip(throttle_cur + yaw_cur, -full, full));
    end
    r.level = VAL_W'(throttle_cur);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
    n_fail++;
  endtask

  always @(posedge clk) begin
    drive_t want;
    drive_t got;
    if (!rst_n) begin
      slew_reg <= SLEW_RST;
      timeout_reg <= TIMEOUT_RST;
      tfull_reg <= TFULL_RST;
      tzero_reg <= TZERO_RST;
      throttle_tgt = 0;
      yaw_tgt = 0;
      throttle_cur = 0;
      yaw_cur = 0;
      cmd_stamp = 32'd0;
      drive_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLEW:    slew_reg <= cfg_wdata[14:0];
          CFG_TIMEOUT: timeout_reg <= cfg_wdata[15:0];
          CFG_TFULL:   tfull_reg <= cfg_wdata[RAW_W-1:0];
          CFG_TZERO:   tzero_reg <= cfg_wdata[RAW_W-1:0];
          default: ;
        endcase
      end
      // results are older than any item accepted on the same edge
      if (out_tvalid && out_tready) begin
        got = drive_t'(out_tdata[48:0]);
        if (drive_q.size() == 0) begin
          report_mismatch("unexpected result, throttle_level", got.level, 0);
        end else begin
          want = drive_q.pop_front();
          if (got.left !== want.left) report_mismatch("left_drive", got.left, want.left);
          if (got.right !== want.right) report_mismatch("right_drive", got.right, want.right);
          if (got.level !== want.level) report_mismatch("throttle_level", got.level, want.level);
          if (got.timed_out !== want.timed_out)
            report_mismatch("timed_out", got.timed_out, want.timed_out);
        end
      end
      if (in_tvalid && in_tready) drive_q.push_back(shape_item(in_tuser == TICK_CODE, in_tdata));
    end
    n_pending <= drive_q.size();
  end

endmodule

@@ verif/tb_tracked_drive_throttle_shaper_unit.sv @@
`timescale 1ns / 100ps
module tb_tracked_drive_throttle_shaper_unit;
  import tdts_pkg::*;

  localparam logic CMD_SET = 1'b0;
  localparam logic CMD_TICK = 1'b1;
  localparam int STALL_LIMIT = 4000;
  localparam int FULL_I = 25600;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit calm = 1'b0;

  // register values of the current phase
  int cur_slew = 51;
  int cur_timeout = 2000;
  int cur_tfull = 750000;
  int cur_tzero = 2250000;

  always #5 clk = ~clk;

  tracked_drive_throttle_shaper_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  tdts_checker #(
    .TICK_CODE (CMD_TICK)
  ) i_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("FAIL tracked_drive_throttle_shaper_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_item(
    input logic [31:0] now, input logic [15:0] thr, input logic [15:0] yaw,
    input logic [16:0] pitch, input logic [23:0] tens, input logic [15:0] corr,
    input logic batt);
    return {6'd0, batt, corr, tens, pitch, yaw, thr, now};
  endfunction

  function automatic int rand_q8();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return int'($urandom_range(0, 2 * FULL_I)) - FULL_I;
    if (pick < 85) return int'($signed(16'($urandom)));
    case ($urandom_range(4))
      0: return 0;
      1: return FULL_I;
      2: return -FULL_I;
      3: return 1;
      default: return -1;
    endcase
  endfunction

  task automatic send_item(input logic kind, input logic [IN_DATA_W-1:0] data);
    if (!calm && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_set(input logic [31:0] now, input int thr, input int yaw,
                          input logic batt);
    send_item(CMD_SET, pack_item(now, 16'(thr), 16'(yaw), 17'($urandom), 24'($urandom),
                                 16'($urandom), batt));
  endtask

  task automatic send_tick(input logic [31:0] now, input int pitch, input int tens,
                           input int corr, input logic batt);
    send_item(CMD_TICK, pack_item(now, 16'($urandom), 16'($urandom), 17'(pitch), 24'(tens),
                                  16'(corr), batt));
  endtask

  // stop sending and let every outstanding item come back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic apply_config(input int slew, input int tout, input int tfull, input int tzero);
    int vals[4];
    vals = '{slew, tout, tfull, tzero};
    drain();
    cur_slew = slew;
    cur_timeout = tout;
    cur_tfull = tfull;
    cur_tzero = tzero;
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      case (i)
        0: cfg_index <= CFG_SLEW;
        1: cfg_index <= CFG_TIMEOUT;
        2: cfg_index <= CFG_TFULL;
        default: cfg_index <= CFG_TZERO;
      endcase
      cfg_wdata <= CFG_DATA_W'(vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int n_items, input bit with_pause);
    logic [31:0] ms;
    int pick;
    int pitch;
    int tens;
    int corr;
    if ($urandom_range(3) == 0) ms = 32'hFFFF_FFFF - $urandom_range(5000);
    else ms = $urandom_range(1, 100000);
    for (int n = 0; n < n_items; n++) begin
      if (with_pause && n == n_items / 2) drain();
      pick = $urandom_range(99);
      if (pick < 18) begin
        send_set(ms, rand_q8(), rand_q8(), $urandom_range(9) == 0);
      end else if (pick < 21) begin
        // disarming set at time zero, or a stray time stamp
        send_set((pick == 18) ? 32'd0 : $urandom, rand_q8(), rand_q8(), 1'b0);
      end else begin
        if (pick < 90) ms += $urandom_range(0, cur_timeout / 8 + 20);
        else if (pick < 95) ms += cur_timeout + $urandom_range(0, 50);
        case ($urandom_range(19))
          0, 1, 2:    pitch = int'($signed(17'($urandom)));
          3, 4, 5, 6: pitch = int'($urandom_range(0, 20 * 256)) + 20 * 256;
          7, 8, 9:    pitch = -(int'($urandom_range(0, 20 * 256)) + 20 * 256);
          10, 11:     pitch = int'($urandom_range(0, 92160)) - 46080;
          default:    pitch = int'($urandom_range(0, 6000)) - 3000;
        endcase
        pick = $urandom_range(99);
        if (pick < 15) tens = int'($signed(24'($urandom)));
        else if (pick < 20) tens = cur_tfull;
        else if (pick < 25) tens = cur_tzero;
        else if (pick < 60 && cur_tzero > cur_tfull)
          tens = cur_tfull + int'($urandom_range(0, cur_tzero - cur_tfull));
        else tens = int'($urandom_range(0, cur_tfull)) - int'($urandom_range(0, 100000));
        pick = $urandom_range(9);
        if (pick < 6) corr = int'($urandom_range(0, 4000)) - 2000;
        else if (pick < 9) corr = int'($urandom_range(0, 2 * FULL_I)) - FULL_I;
        else corr = int'($signed(16'($urandom)));
        send_tick(($urandom_range(99) < 4) ? $urandom : ms, pitch, tens, corr,
                  $urandom_range(9) == 0);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset settings
    send_tick(32'd500, 0, 0, 0, 1'b0);
    send_set(32'd1000, 32767, -32768, 1'b0);
    send_tick(32'd1000, 0, 0, 25600, 1'b0);
    send_tick(32'd1100, -25 * 256, 0, 0, 1'b0);
    send_tick(32'd1150, 25 * 256, 2249999, 0, 1'b0);
    send_tick(32'd1200, 46080, 750000, -32768, 1'b0);
    send_tick(32'd1300, -46080, 2250000, 32767, 1'b0);
    send_tick(32'd1400, 0, 1500000, -25600, 1'b1);
    send_set(32'd1500, 20000, 0, 1'b1);
    send_tick(32'd1500, 0, -8388608, 0, 1'b0);
    send_tick(32'd1600, 0, 100, 0, 1'b0);
    send_set(32'd1700, -25600, 300, 1'b0);
    send_tick(32'd1700, 0, 8388607, 0, 1'b0);
    send_tick(32'd1800, 0, 0, 0, 1'b0);
    send_tick(32'd1900, 0, 0, 0, 1'b0);
    send_set(32'd2000, -30, -300, 1'b0);
    send_tick(32'd2000, 0, 0, 0, 1'b0);
    send_tick(32'd4000, 0, 0, 0, 1'b0);
    send_set(32'd0, 25600, 25600, 1'b0);
    send_tick(32'hFFFF_FFFF, 65535, 0, 0, 1'b0);
    send_set(32'hFFFF_FF00, 1000, 0, 1'b0);
    send_tick(32'hFFFF_FF10, -65536, 0, 0, 1'b0);
    send_set(32'd5000, 1000, -25600, 1'b0);
    send_tick(32'd4000, 0, 0, 0, 1'b0);

    // register extremes, then crossed tension points, then random settings
    apply_config(25600, 0, 0, 1);
    run_random(80, 1'b1);
    apply_config(1, 65535, 8388607, 8388607);
    run_random(80, 1'b0);
    apply_config(300, 500, 3000000, 20000);
    run_random(80, 1'b0);
    for (int p = 0; p < 3; p++) begin
      cur_tfull = $urandom_range(0, 2000000);
      cur_tzero = cur_tfull + $urandom_range(1, 3000000);
      apply_config($urandom_range(1, 2000), $urandom_range(50, 3000), cur_tfull, cur_tzero);
      calm = (p == 1);
      run_random(100, p == 2);
    end
    calm = 1'b0;

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS tracked_drive_throttle_shaper_unit");
    end else begin
      $display("FAIL tracked_drive_throttle_shaper_unit");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/tdts_pkg.sv
src/tdts_ctrl.sv
src/tdts_dp.sv
src/tracked_drive_throttle_shaper_unit.sv
src/tdts_checker.sv
verif/tdts_checker.sv
verif/tb_tracked_drive_throttle_shaper_unit.sv
